FILE: design/som_bmu_pkg.sv
`timescale 1ns / 1ps

package som_bmu_pkg;

  localparam int DEFAULT_MAX_NEURONS = 1024;
  localparam int DEFAULT_MAX_DIMS    = 16;

  localparam int FUNC_W      = 1;
  localparam int NEURON_W    = 10;
  localparam int COMP_W      = 4;
  localparam int VALUE_W     = 17;
  localparam int WIN_IDX_W   = 10;
  localparam int DIST_W      = 37;
  localparam int SQ_W        = 2 * VALUE_W;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int NEURONS_W   = 11;
  localparam int DIMS_W      = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_NEURONS_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMS_IN_USE    = 1'd1;

  localparam logic [NEURONS_W-1:0] NEURONS_RESET = 11'd1024;
  localparam logic [DIMS_W-1:0]    DIMS_RESET    = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  localparam logic [VALUE_W-1:0] VALUE_ONE = 17'd65536;
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  // Control that travels with one weight component through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic tail;
  } step_ctl_t;

endpackage

FILE: design/som_bmu_if.sv
`timescale 1ns / 1ps

interface som_bmu_in_if import som_bmu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NEURON_W-1:0] neuron_index;
  logic [COMP_W-1:0]   component_index;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, func, neuron_index, component_index, value, input ready);
  modport sink (input valid, func, neuron_index, component_index, value, output ready);
endinterface

interface som_bmu_out_if import som_bmu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WIN_IDX_W-1:0] winner_index;
  logic [DIST_W-1:0]    winner_distance;

  modport source (output valid, winner_index, winner_distance, input ready);
  modport sink (input valid, winner_index, winner_distance, output ready);
endinterface

FILE: design/som_bmu_weight_mem.sv
`timescale 1ns / 1ps

module som_bmu_weight_mem import som_bmu_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_NEURONS * DEFAULT_MAX_DIMS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/som_bmu_dist_unit.sv
`timescale 1ns / 1ps

module som_bmu_dist_unit import som_bmu_pkg::*; #(
  parameter int SUM_W = DIST_W
) (
  input  logic               clk,
  input  logic               rst,
  input  step_ctl_t          ctl_in,
  input  logic [VALUE_W-1:0] weight,
  input  logic [VALUE_W-1:0] sample,
  output step_ctl_t          cand_ctl,
  output logic [SUM_W-1:0]   cand_sum
);

  step_ctl_t          ctl1;
  step_ctl_t          ctl2;
  logic [VALUE_W-1:0] diff;
  logic [SQ_W-1:0]    sq;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   acc_next;

  assign acc_next = (ctl2.first ? '0 : acc) + SUM_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1     <= '0;
      ctl2     <= '0;
      cand_ctl <= '0;
    end else begin
      ctl1     <= ctl_in;
      ctl2     <= ctl1;
      cand_ctl <= {ctl2.valid & ctl2.last, ctl2.first, ctl2.last, ctl2.tail};
    end
  end

  always_ff @(posedge clk) begin
    diff <= (weight > sample) ? weight - sample : sample - weight;
    sq   <= SQ_W'(diff) * SQ_W'(diff);
    if (ctl2.valid) begin
      acc <= acc_next;
    end
    cand_sum <= acc_next;
  end

endmodule

FILE: design/som_bmu_min_track.sv
`timescale 1ns / 1ps

module som_bmu_min_track import som_bmu_pkg::*; #(
  parameter int NB    = $clog2(DEFAULT_MAX_NEURONS),
  parameter int SUM_W = DIST_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  step_ctl_t        cand_ctl,
  input  logic [SUM_W-1:0] cand_sum,
  output logic [NB-1:0]    best_idx,
  output logic [SUM_W-1:0] best_sum,
  output logic             done
);

  logic [NB-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cand_ctl.valid & cand_ctl.tail;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
    end else if (cand_ctl.valid) begin
      if (idx == '0 || cand_sum < best_sum) begin
        best_sum <= cand_sum;
        best_idx <= idx;
      end
      idx <= idx + NB'(1);
    end
  end

endmodule

FILE: design/som_best_matching_unit_search.sv
`timescale 1ns / 1ps

// Winner search for a self-organizing map by squared Euclidean distance. Weight items and
// sample components that do not end a sample are accepted back to back. The sample
// component at index dims_in_use-1 starts a search, during which the block takes no item;
// one subtract, square and accumulate unit handles one weight component per cycle, read
// from the single read port of the weight store. The result item is held in an output
// register until it is taken, and the block keeps accepting items meanwhile; a further
// search then waits at its end for that register to free up. Stores come out of reset
// unwritten and must be loaded before they are searched.
module som_best_matching_unit_search import som_bmu_pkg::*; #(
  parameter int MAX_NEURONS = DEFAULT_MAX_NEURONS,
  parameter int MAX_DIMS    = DEFAULT_MAX_DIMS
) (
  input  logic                   clk,
  input  logic                   rst,
  som_bmu_in_if.sink             items,
  som_bmu_out_if.source          results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_NEURONS * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NB    = $clog2(MAX_NEURONS);
  localparam int DB    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW    = $clog2(MAX_NEURONS + 1);
  localparam int DCW   = $clog2(MAX_DIMS + 1);
  localparam int RAW_SUM_W = 33 + $clog2(MAX_DIMS);
  localparam int SUM_W = (RAW_SUM_W > DIST_W) ? RAW_SUM_W : DIST_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [NEURONS_W-1:0] neurons_reg;
  logic [DIMS_W-1:0]    dims_reg;
  logic [CW-1:0]        count_eff;
  logic [DCW-1:0]       dims_eff;

  logic [NB-1:0] n;
  logic [DB-1:0] c;
  logic [AW-1:0] base;

  logic               accept;
  logic [VALUE_W-1:0] value_sat;
  logic               weight_ok;
  logic               sample_ok;
  logic               start;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  logic [VALUE_W-1:0] sample_buf [MAX_DIMS];
  logic [VALUE_W-1:0] sample_q;
  logic [VALUE_W-1:0] weight_q;

  step_ctl_t issue_ctl;
  step_ctl_t issue_q;
  step_ctl_t cand_ctl;
  logic [SUM_W-1:0] cand_sum;
  logic [NB-1:0]    best_idx;
  logic [SUM_W-1:0] best_sum;
  logic             done;

  logic                 out_valid;
  logic                 out_load;
  logic [WIN_IDX_W-1:0] out_idx;
  logic [DIST_W-1:0]    out_dist;

  always_comb begin
    if (neurons_reg == '0) begin
      count_eff = CW'(1);
    end else if (int'(neurons_reg) > MAX_NEURONS) begin
      count_eff = CW'(MAX_NEURONS);
    end else begin
      count_eff = CW'(neurons_reg);
    end
    if (dims_reg == '0) begin
      dims_eff = DCW'(1);
    end else if (int'(dims_reg) > MAX_DIMS) begin
      dims_eff = DCW'(MAX_DIMS);
    end else begin
      dims_eff = DCW'(dims_reg);
    end
  end

  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign value_sat   = (items.value > VALUE_ONE) ? VALUE_ONE : items.value;
  assign weight_ok   = (items.func == FUNC_WEIGHT) && (int'(items.neuron_index) < MAX_NEURONS)
                       && (int'(items.component_index) < MAX_DIMS);
  assign sample_ok   = (items.func == FUNC_SAMPLE) && (int'(items.component_index) < MAX_DIMS);
  assign start       = accept && sample_ok
                       && (int'(items.component_index) + 1 == int'(dims_eff));
  assign wr_en       = accept && weight_ok;
  assign wr_addr     = AW'(int'(items.neuron_index) * MAX_DIMS + int'(items.component_index));

  always_comb begin
    issue_ctl.valid = (state == ST_RUN);
    issue_ctl.first = (c == '0);
    issue_ctl.last  = (c == DB'(dims_eff - DCW'(1)));
    issue_ctl.tail  = issue_ctl.last && (n == NB'(count_eff - CW'(1)));
  end

  assign out_load = (state == ST_FINISH) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_ctl.tail) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      neurons_reg <= NEURONS_RESET;
      dims_reg    <= DIMS_RESET;
      issue_q     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      issue_q <= issue_ctl;
      if (cfg_we) begin
        case (cfg_index)
          REG_NEURONS_IN_USE: neurons_reg <= NEURONS_W'(cfg_data);
          REG_DIMS_IN_USE:    dims_reg    <= DIMS_W'(cfg_data);
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= '0;
      c    <= '0;
      base <= '0;
    end else if (state == ST_RUN) begin
      if (issue_ctl.last) begin
        c    <= '0;
        n    <= n + NB'(1);
        base <= base + AW'(MAX_DIMS);
      end else begin
        c <= c + DB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sample_ok) begin
      sample_buf[DB'(items.component_index)] <= value_sat;
    end
    sample_q <= sample_buf[c];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx  <= WIN_IDX_W'(best_idx);
      out_dist <= (best_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(best_sum);
    end
  end

  assign results.valid           = out_valid;
  assign results.winner_index    = out_idx;
  assign results.winner_distance = out_dist;

  som_bmu_weight_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_weight_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (value_sat),
    .raddr (base + AW'(c)),
    .rdata (weight_q)
  );

  som_bmu_dist_unit #(
    .SUM_W (SUM_W)
  ) u_dist_unit (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (issue_q),
    .weight   (weight_q),
    .sample   (sample_q),
    .cand_ctl (cand_ctl),
    .cand_sum (cand_sum)
  );

  som_bmu_min_track #(
    .NB    (NB),
    .SUM_W (SUM_W)
  ) u_min_track (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cand_ctl (cand_ctl),
    .cand_sum (cand_sum),
    .best_idx (best_idx),
    .best_sum (best_sum),
    .done     (done)
  );

  // The component counter never passes the last component in use during a search.
  a_comp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (int'(c) < int'(dims_eff)))
    else $error("component counter beyond dims in use");

  // Neuron distances arrive only while a search is under way.
  a_cand_in_search: assert property (@(posedge clk) disable iff (rst)
    cand_ctl.valid |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("distance candidate outside a search");

  // The end of a search is seen only after all reads were issued.
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_DRAIN))
    else $error("search finished outside drain");

endmodule

FILE: bench/som_best_matching_unit_search_tb.sv
`timescale 1ns / 1ps

module som_best_matching_unit_search_tb;
  import som_bmu_pkg::*;

  localparam int MAP_SIZE      = DEFAULT_MAX_NEURONS * DEFAULT_MAX_DIMS;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int LARGE_NEURONS = 256;
  localparam int PAD_W         = CFG_DATA_W - DIMS_W;
  localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [WIN_IDX_W-1:0] index;
    logic [DIST_W-1:0]    distance;
  } winner_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  som_bmu_in_if  item_ch ();
  som_bmu_out_if result_ch ();

  som_best_matching_unit_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [VALUE_W-1:0]   weight_mem [MAP_SIZE];
  logic [VALUE_W-1:0]   sample_mem [DEFAULT_MAX_DIMS];
  bit                   weight_loaded [MAP_SIZE];
  bit                   sample_loaded [DEFAULT_MAX_DIMS];
  logic [NEURONS_W-1:0] neurons_reg = NEURONS_RESET;
  logic [DIMS_W-1:0]    dims_reg    = DIMS_RESET;
  winner_t              pending_winners [$];

  int errors           = 0;
  int items_sent       = 0;
  int searches_checked = 0;
  int reg_writes       = 0;
  int stall_left       = 0;
  bit idle_en          = 1'b1;
  bit hold_req         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int eff_neurons();
    if (neurons_reg == 0) return 1;
    if (neurons_reg > DEFAULT_MAX_NEURONS) return DEFAULT_MAX_NEURONS;
    return int'(neurons_reg);
  endfunction

  function automatic int eff_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > DEFAULT_MAX_DIMS) return DEFAULT_MAX_DIMS;
    return int'(dims_reg);
  endfunction

  function automatic winner_t search_map();
    winner_t            w;
    logic [39:0]        acc;
    logic [39:0]        best;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] diff;
    int                 dims;
    dims = eff_dims();
    best = '0;
    w.index = '0;
    for (int n = 0; n < eff_neurons(); n++) begin
      acc = '0;
      for (int c = 0; c < dims; c++) begin
        a = weight_mem[n * DEFAULT_MAX_DIMS + c];
        b = sample_mem[c];
        diff = (a > b) ? a - b : b - a;
        acc = acc + 40'(diff) * 40'(diff);
      end
      if (n == 0 || acc < best) begin
        best = acc;
        w.index = WIN_IDX_W'(n);
      end
    end
    w.distance = (best > 40'(DIST_MAX)) ? DIST_MAX : best[DIST_W-1:0];
    return w;
  endfunction

  function automatic void apply_item(input logic [FUNC_W-1:0] f, input logic [NEURON_W-1:0] n,
                                     input logic [COMP_W-1:0] c, input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] kept;
    int                 addr;
    kept = (v > VALUE_ONE) ? VALUE_ONE : v;
    addr = int'(n) * DEFAULT_MAX_DIMS + int'(c);
    if (f == FUNC_WEIGHT) begin
      weight_mem[addr] = kept;
      weight_loaded[addr] = 1'b1;
    end else begin
      sample_mem[c] = kept;
      sample_loaded[c] = 1'b1;
      if (int'(c) == eff_dims() - 1) pending_winners = {pending_winners, search_map()};
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VALUE_ONE;
      2: return VALUE_TOP;
      3, 4: return VALUE_W'($urandom_range(0, 4) * 16384);
      default: return VALUE_W'($urandom_range(0, 131071));
    endcase
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [NEURON_W-1:0] n,
                           input logic [COMP_W-1:0] c, input logic [VALUE_W-1:0] v);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.func            <= f;
    item_ch.neuron_index    <= n;
    item_ch.component_index <= c;
    item_ch.value           <= v;
    do @(posedge clk); while (!item_ch.ready);
    apply_item(f, n, c, v);
    items_sent++;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_NEURONS_IN_USE) neurons_reg = data[NEURONS_W-1:0];
    else dims_reg = data[DIMS_W-1:0];
    reg_writes++;
  endtask

  // Every weight and sample entry that a search can read is written before any search runs.
  task automatic load_region();
    for (int n = 0; n < eff_neurons(); n++) begin
      for (int c = 0; c < eff_dims(); c++) begin
        if (!weight_loaded[n * DEFAULT_MAX_DIMS + c]) begin
          send_item(FUNC_WEIGHT, NEURON_W'(n), COMP_W'(c), pick_value());
        end
      end
    end
    for (int c = 0; c < eff_dims(); c++) begin
      if (!sample_loaded[c]) send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(c), pick_value());
    end
  endtask

  task automatic set_config(input int neurons_raw, input int dims_raw, input bit with_dims,
                            input bit fill);
    logic [PAD_W-1:0] pad;
    pad = PAD_W'($urandom);
    drain();
    write_reg(REG_NEURONS_IN_USE, CFG_DATA_W'(neurons_raw));
    if (with_dims) write_reg(REG_DIMS_IN_USE, {pad, DIMS_W'(dims_raw)});
    cfg_we <= 1'b0;
    if (fill) load_region();
  endtask

  task automatic send_round();
    int nn;
    int dd;
    nn = eff_neurons();
    dd = eff_dims();
    if ($urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(0, 4)) begin
        send_item(FUNC_WEIGHT, NEURON_W'($urandom_range(0, nn - 1)),
                  COMP_W'($urandom_range(0, dd - 1)), pick_value());
      end
      repeat ($urandom_range(0, dd - 1)) begin
        send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'($urandom_range(0, dd - 1)),
                  pick_value());
      end
      send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(dd - 1), pick_value());
    end else begin
      repeat (3) begin
        send_item(FUNC_W'($urandom), NEURON_W'($urandom), COMP_W'($urandom),
                  VALUE_W'($urandom));
      end
    end
  endtask

  task automatic test_dims_reset_max_distance();
    set_config(1, 0, 1'b0, 1'b0);
    for (int c = 0; c < DEFAULT_MAX_DIMS; c++) send_item(FUNC_WEIGHT, '0, COMP_W'(c), '0);
    for (int c = 0; c < DEFAULT_MAX_DIMS; c++) begin
      send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(c), (c % 2) ? VALUE_TOP : VALUE_ONE);
    end
    set_config(0, 31, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, NEURON_W'(1023), COMP_W'(15), VALUE_ONE);
  endtask

  task automatic test_ties_and_saturation();
    set_config(3, 2, 1'b1, 1'b0);
    send_item(FUNC_WEIGHT, NEURON_W'(0), COMP_W'(0), '0);
    send_item(FUNC_WEIGHT, NEURON_W'(0), COMP_W'(1), '0);
    send_item(FUNC_WEIGHT, NEURON_W'(1), COMP_W'(0), VALUE_ONE);
    send_item(FUNC_WEIGHT, NEURON_W'(1), COMP_W'(1), VALUE_TOP);
    send_item(FUNC_WEIGHT, NEURON_W'(2), COMP_W'(0), '0);
    send_item(FUNC_WEIGHT, NEURON_W'(2), COMP_W'(1), '0);
    send_item(FUNC_SAMPLE, NEURON_W'(0), COMP_W'(0), VALUE_ONE);
    send_item(FUNC_SAMPLE, NEURON_W'(0), COMP_W'(1), '0);
    send_item(FUNC_SAMPLE, NEURON_W'(512), COMP_W'(1), VALUE_ONE);
    send_item(FUNC_SAMPLE, NEURON_W'(1023), COMP_W'(15), VALUE_W'(777));
    send_item(FUNC_SAMPLE, NEURON_W'(0), COMP_W'(0), '0);
    send_item(FUNC_SAMPLE, NEURON_W'(0), COMP_W'(1), '0);
    send_item(FUNC_WEIGHT, NEURON_W'(1023), COMP_W'(15), VALUE_TOP);
  endtask

  task automatic test_large_map();
    set_config(LARGE_NEURONS, 0, 1'b1, 1'b1);
    repeat (2) send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(0), pick_value());
    send_item(FUNC_WEIGHT, NEURON_W'(LARGE_NEURONS - 1), COMP_W'(0), VALUE_W'(40000));
    send_item(FUNC_SAMPLE, NEURON_W'(0), COMP_W'(0), VALUE_W'(40000));
    set_config(LARGE_NEURONS - 1, 1, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(0), pick_value());
  endtask

  task automatic test_output_backpressure();
    set_config(4, 2, 1'b1, 1'b1);
    hold_req = 1'b1;
    repeat (6) send_item(FUNC_SAMPLE, NEURON_W'($urandom), COMP_W'(1), pick_value());
    drain();
  endtask

  task automatic test_random_phases();
    int neurons_raw;
    int dims_raw;
    int target;
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 9))
        0: dims_raw = 31;
        1: dims_raw = 16;
        2: dims_raw = 0;
        default: dims_raw = $urandom_range(1, 8);
      endcase
      neurons_raw = (dims_raw > 8) ? $urandom_range(0, 2) : $urandom_range(0, 16);
      set_config(neurons_raw, dims_raw, 1'b1, 1'b1);
      target = items_sent + 36;
      while (items_sent < target) send_round();
    end
    drain();
  endtask

  task automatic test_back_to_back();
    int target;
    idle_en = 1'b0;
    set_config($urandom_range(2, 12), $urandom_range(1, 6), 1'b1, 1'b1);
    target = items_sent + 36;
    while (items_sent < target) send_round();
    drain();
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    winner_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_winners.size() == 0) begin
        report_mismatch($sformatf("result index %0d distance %0d with no search pending",
                                  result_ch.winner_index, result_ch.winner_distance));
      end else begin
        want = pending_winners.pop_front();
        searches_checked++;
        if (result_ch.winner_index !== want.index) begin
          report_mismatch($sformatf("winner_index %0d, predicted %0d",
                                    result_ch.winner_index, want.index));
        end
        if (result_ch.winner_distance !== want.distance) begin
          report_mismatch($sformatf("winner_distance %0d, predicted %0d",
                                    result_ch.winner_distance, want.distance));
        end
      end
    end
  end

  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_NEURONS_IN_USE;
    cfg_data                <= '0;
    item_ch.valid           <= 1'b0;
    item_ch.func            <= FUNC_WEIGHT;
    item_ch.neuron_index    <= '0;
    item_ch.component_index <= '0;
    item_ch.value           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_dims_reset_max_distance();
    test_ties_and_saturation();
    test_large_map();
    test_output_backpressure();
    test_random_phases();
    test_back_to_back();
    if (pending_winners.size() != 0) begin
      report_mismatch($sformatf("%0d predicted winners never arrived", pending_winners.size()));
    end
    $display("Sent %0d items, compared %0d winners, made %0d register writes.",
             items_sent, searches_checked, reg_writes);
    $display("Zero and oversized counts, ties, saturation, a %0d-neuron map and a %0d-cycle stall.",
             LARGE_NEURONS, HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/som_bmu_pkg.sv
design/som_bmu_if.sv
design/som_bmu_weight_mem.sv
design/som_bmu_dist_unit.sv
design/som_bmu_min_track.sv
design/som_best_matching_unit_search.sv
bench/som_best_matching_unit_search_tb.sv
